// ===== rtl/fim_pkg.sv =====
// ----------------------------------------------------------------------------
// fim_pkg
// Shared types and constants for the frame interval monitor.
// ----------------------------------------------------------------------------
package fim_pkg;

	localparam int DEF_HISTORY_DEPTH = 64;
	localparam int DEF_TIME_WIDTH    = 48;

	localparam int MODE_W      = 2;
	localparam int CFG_INDEX_W = 1;
	localparam int CFG_DATA_W  = 32;
	localparam int RATE_W      = 16;

	localparam logic [RATE_W-1:0]     RATE_MAX  = '1;
	localparam logic [CFG_DATA_W-1:0] TPS_RESET = 32'd10000000;

	// event codes
	typedef enum logic [MODE_W-1:0] {
		MODE_FRAME  = 2'd0,
		MODE_RESUME = 2'd1,
		MODE_PAUSE  = 2'd2,
		MODE_RESET  = 2'd3
	} mode_t;

	// register indexes
	localparam logic [CFG_INDEX_W-1:0] CFG_TICKS_PER_SECOND = 1'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_MIN_FRAME_TICKS  = 1'd1;

	// controller -> datapath
	typedef struct packed {
		logic capture;    // latch request
		logic calc;       // interval and pause length
		logic check;      // lock test, distance to mean, window sum; non-frame events
		logic apply;      // frame bookkeeping
		logic mem_read;   // fetch oldest sample
		logic evict;      // drop oldest sample from sum
		logic write;      // store sample
		logic div_start;  // start mean division
		logic mean_load;  // take quotient
		logic out_load;   // fill output register
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic is_frame;
		logic accepted;
		logic keep;
		logic full;
		logic div_done;
	} status_t;

endpackage

// ===== rtl/frame_interval_monitor_core.sv =====
// ----------------------------------------------------------------------------
// frame_interval_monitor_core
// Frame timing statistics from timestamped frame, pause, resume and reset
// events.
// ----------------------------------------------------------------------------
// Each request (mode, timestamp) yields exactly one response carrying the
// frame status, interval, running mean, latched frames-per-second and pause
// flag. Requests are handled one at a time: pause, resume and reset pass
// the calc and check states; rejected or outlier frame marks add the apply
// state; a frame mark that enters the history goes on through write, divider
// start and divider wait, with an evict state before write when the history
// is full and the oldest sample is read back. The mean division dominates: a
// radix-8 divider retires three quotient bits per cycle. The response sits
// in an output register, so a new request is taken while the previous
// response still waits. Configuration writes are always taken (cfg_ready is
// tied high) and must only be issued while no request is in flight.
// ----------------------------------------------------------------------------
module frame_interval_monitor_core #(
	parameter int HISTORY_DEPTH = fim_pkg::DEF_HISTORY_DEPTH,
	parameter int TIME_WIDTH    = fim_pkg::DEF_TIME_WIDTH
) (
	input  logic                               clk,
	input  logic                               arst_n,

	// configuration writes
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [fim_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [fim_pkg::CFG_DATA_W-1:0]     cfg_data,

	// request channel
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [fim_pkg::MODE_W-1:0]         mode,
	input  logic [TIME_WIDTH-1:0]              timestamp,

	// response channel
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic                               frame_accepted,
	output logic [TIME_WIDTH-1:0]              frame_ticks,
	output logic [TIME_WIDTH-1:0]              average_ticks,
	output logic [fim_pkg::RATE_W-1:0]         frame_rate,
	output logic [$clog2(HISTORY_DEPTH+1)-1:0] samples_held,
	output logic                               paused
);
	import fim_pkg::*;

	cmd_t    cmd;
	status_t status;

	// registers live in the datapath; writes are registered there
	assign cfg_ready = 1'b1;

	fim_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status   (status),
		.cmd      (cmd)
	);

	fim_datapath #(
		.HISTORY_DEPTH(HISTORY_DEPTH),
		.TIME_WIDTH   (TIME_WIDTH)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.status        (status),
		.cfg_we        (cfg_valid),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.mode          (mode),
		.timestamp     (timestamp),
		.frame_accepted(frame_accepted),
		.frame_ticks   (frame_ticks),
		.average_ticks (average_ticks),
		.frame_rate    (frame_rate),
		.samples_held  (samples_held),
		.paused        (paused)
	);

`ifndef SYNTHESIS
	// the output register is never overwritten while a response is pending
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_valid || out_ready))
		else $error("response overwritten before it was taken");

	// an accepted request closes the input until it is fully processed
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("request accepted while another is in flight");

	// a mark that did not close a frame reports no interval
	a_ticks_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !frame_accepted) |-> (frame_ticks == '0))
		else $error("interval reported for a frame that was not accepted");

	// the history never holds more samples than it has slots
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (samples_held <= HISTORY_DEPTH))
		else $error("sample count beyond history depth");
`endif

endmodule

// ===== rtl/fim_ctrl.sv =====
// ----------------------------------------------------------------------------
// fim_ctrl
// Sequencer for one request at a time; owns the output valid flag.
// ----------------------------------------------------------------------------
module fim_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	output logic             out_valid,
	input  logic             out_ready,
	input  fim_pkg::status_t status,
	output fim_pkg::cmd_t    cmd
);
	import fim_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE,
		S_CALC,
		S_CHECK,
		S_APPLY,
		S_EVICT,
		S_WRITE,
		S_DIV_START,
		S_DIV_WAIT,
		S_DONE
	} state_t;

	state_t state_q;
	state_t state_nxt;
	logic   out_valid_q;
	logic   out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_nxt   = S_CALC;
				end
			end
			S_CALC: begin
				cmd.calc  = 1'b1;
				state_nxt = S_CHECK;
			end
			S_CHECK: begin
				cmd.check = 1'b1;
				state_nxt = status.is_frame ? S_APPLY : S_DONE;
			end
			S_APPLY: begin
				cmd.apply = 1'b1;
				if (status.accepted && status.keep) begin
					if (status.full) begin
						cmd.mem_read = 1'b1;
						state_nxt    = S_EVICT;
					end else begin
						state_nxt = S_WRITE;
					end
				end else begin
					state_nxt = S_DONE;
				end
			end
			S_EVICT: begin
				cmd.evict = 1'b1;
				state_nxt = S_WRITE;
			end
			S_WRITE: begin
				cmd.write = 1'b1;
				state_nxt = S_DIV_START;
			end
			S_DIV_START: begin
				cmd.div_start = 1'b1;
				state_nxt     = S_DIV_WAIT;
			end
			S_DIV_WAIT: begin
				if (status.div_done) begin
					cmd.mean_load = 1'b1;
					state_nxt     = S_DONE;
				end
			end
			S_DONE: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_nxt    = S_IDLE;
				end
			end
			default: state_nxt = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ===== rtl/fim_divider.sv =====
// ----------------------------------------------------------------------------
// fim_divider
// Radix-8 restoring divider: running sum over sample count, 3 bits a cycle.
// ----------------------------------------------------------------------------
module fim_divider #(
	parameter int HISTORY_DEPTH = fim_pkg::DEF_HISTORY_DEPTH,
	parameter int TIME_WIDTH    = fim_pkg::DEF_TIME_WIDTH
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	input  logic [TIME_WIDTH+$clog2(HISTORY_DEPTH+1)-1:0] dividend,
	input  logic [$clog2(HISTORY_DEPTH+1)-1:0]    divisor,
	output logic [TIME_WIDTH-1:0]                 quotient,
	output logic                                  done
);
	import fim_pkg::*;

	localparam int CNT_W     = $clog2(HISTORY_DEPTH + 1);
	localparam int STEP_BITS = 3;
	localparam int STEPS     = (TIME_WIDTH + STEP_BITS - 1) / STEP_BITS;
	localparam int QB        = STEPS * STEP_BITS;
	localparam int EXT_W     = QB + CNT_W;
	localparam int SC_W      = $clog2(STEPS + 1);

	// mean never exceeds the largest sample, so the bits above QB form a
	// starting remainder already below the divisor
	logic [EXT_W-1:0] ext_dvd;
	logic [CNT_W-1:0] rem_q;
	logic [QB-1:0]    dvd_q;
	logic [QB-1:0]    quo_q;
	logic [CNT_W-1:0] den_q;
	logic [SC_W-1:0]  cnt_q;
	logic             busy_q;
	logic             done_q;

	logic [CNT_W-1:0] rem_nxt;
	logic [QB-1:0]    dvd_nxt;
	logic [QB-1:0]    quo_nxt;

	assign ext_dvd  = EXT_W'(dividend);
	assign quotient = quo_q[TIME_WIDTH-1:0];
	assign done     = done_q;

	always_comb begin
		logic [CNT_W:0] trial;
		rem_nxt = rem_q;
		dvd_nxt = dvd_q;
		quo_nxt = quo_q;
		for (int i = 0; i < STEP_BITS; i++) begin
			trial   = {rem_nxt, dvd_nxt[QB-1]};
			dvd_nxt = {dvd_nxt[QB-2:0], 1'b0};
			if (trial >= {1'b0, den_q}) begin
				rem_nxt = CNT_W'(trial - {1'b0, den_q});
				quo_nxt = {quo_nxt[QB-2:0], 1'b1};
			end else begin
				rem_nxt = trial[CNT_W-1:0];
				quo_nxt = {quo_nxt[QB-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= SC_W'(STEPS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == SC_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= ext_dvd[EXT_W-1:QB];
			dvd_q <= ext_dvd[QB-1:0];
			quo_q <= '0;
			den_q <= divisor;
		end else if (busy_q) begin
			rem_q <= rem_nxt;
			dvd_q <= dvd_nxt;
			quo_q <= quo_nxt;
		end
	end

endmodule

// ===== rtl/fim_datapath.sv =====
// ----------------------------------------------------------------------------
// fim_datapath
// Timing state, sample history memory, window counters and output register.
// ----------------------------------------------------------------------------
module fim_datapath #(
	parameter int HISTORY_DEPTH = fim_pkg::DEF_HISTORY_DEPTH,
	parameter int TIME_WIDTH    = fim_pkg::DEF_TIME_WIDTH
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  fim_pkg::cmd_t                          cmd,
	output fim_pkg::status_t                       status,
	input  logic                                   cfg_we,
	input  logic [fim_pkg::CFG_INDEX_W-1:0]        cfg_index,
	input  logic [fim_pkg::CFG_DATA_W-1:0]         cfg_data,
	input  logic [fim_pkg::MODE_W-1:0]             mode,
	input  logic [TIME_WIDTH-1:0]                  timestamp,
	output logic                                   frame_accepted,
	output logic [TIME_WIDTH-1:0]                  frame_ticks,
	output logic [TIME_WIDTH-1:0]                  average_ticks,
	output logic [fim_pkg::RATE_W-1:0]             frame_rate,
	output logic [$clog2(HISTORY_DEPTH+1)-1:0]     samples_held,
	output logic                                   paused
);
	import fim_pkg::*;

	localparam int CNT_W  = $clog2(HISTORY_DEPTH + 1);
	localparam int SUM_W  = TIME_WIDTH + CNT_W;
	localparam int HEAD_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
	localparam int CMP_W  = (TIME_WIDTH > CFG_DATA_W) ? TIME_WIDTH : CFG_DATA_W;

	// configuration
	logic [CFG_DATA_W-1:0] tps_q;
	logic [CFG_DATA_W-1:0] min_q;

	// request and per-request scratch
	mode_t                 mode_q;
	logic [TIME_WIDTH-1:0] ts_q;
	logic [TIME_WIDTH-1:0] iv_q;
	logic [TIME_WIDTH-1:0] aux_q;
	logic [TIME_WIDTH-1:0] diff_q;
	logic [TIME_WIDTH-1:0] wsum_q;
	logic                  acc_q;
	logic [TIME_WIDTH-1:0] rd_q;

	// persistent state
	logic [TIME_WIDTH-1:0] prev_q;
	logic [TIME_WIDTH-1:0] pause_q;
	logic                  stopped_q;
	logic [HEAD_W-1:0]     head_q;
	logic [CNT_W-1:0]      count_q;
	logic [SUM_W-1:0]      sum_q;
	logic [TIME_WIDTH-1:0] mean_q;
	logic [RATE_W-1:0]     wframes_q;
	logic [TIME_WIDTH-1:0] wticks_q;
	logic [RATE_W-1:0]     rate_q;

	logic [TIME_WIDTH-1:0] hist_mem [HISTORY_DEPTH];

	// output register
	logic                  o_acc_q;
	logic [TIME_WIDTH-1:0] o_ticks_q;
	logic [TIME_WIDTH-1:0] o_mean_q;
	logic [RATE_W-1:0]     o_rate_q;
	logic [CNT_W-1:0]      o_count_q;
	logic                  o_paused_q;

	logic                  is_frame;
	logic                  reject;
	logic                  full;
	logic [TIME_WIDTH:0]   wadd;
	logic [TIME_WIDTH-1:0] wsat;
	logic [RATE_W-1:0]     frames_inc;
	logic                  window_close;
	logic [HEAD_W-1:0]     head_nxt;
	logic [TIME_WIDTH-1:0] quotient;
	logic                  div_done;

	assign is_frame = (mode_q == MODE_FRAME);
	assign full     = (count_q == CNT_W'(HISTORY_DEPTH));
	assign reject   = (min_q != '0) && (CMP_W'(iv_q) < CMP_W'(min_q));

	assign wadd = {1'b0, wticks_q} + {1'b0, iv_q};
	assign wsat = wadd[TIME_WIDTH] ? '1 : wadd[TIME_WIDTH-1:0];

	assign frames_inc   = (wframes_q == RATE_MAX) ? wframes_q : wframes_q + 1'b1;
	assign window_close = CMP_W'(wsum_q) > CMP_W'(tps_q);
	assign head_nxt     = (head_q == HEAD_W'(HISTORY_DEPTH - 1)) ? '0 : head_q + 1'b1;

	assign status.is_frame = is_frame;
	assign status.accepted = acc_q;
	assign status.keep     = CMP_W'(diff_q) < CMP_W'(tps_q);
	assign status.full     = full;
	assign status.div_done = div_done;

	fim_divider #(
		.HISTORY_DEPTH(HISTORY_DEPTH),
		.TIME_WIDTH   (TIME_WIDTH)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cmd.div_start),
		.dividend(sum_q),
		.divisor (count_q),
		.quotient(quotient),
		.done    (div_done)
	);

	// scratch registers
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			mode_q <= mode_t'(mode);
			ts_q   <= timestamp;
		end
		if (cmd.calc) begin
			iv_q  <= ts_q - prev_q;
			aux_q <= ts_q - pause_q;
		end
		if (cmd.check) begin
			acc_q  <= is_frame && !reject;
			diff_q <= (iv_q >= mean_q) ? iv_q - mean_q : mean_q - iv_q;
			wsum_q <= wsat;
		end
	end

	// sample history
	always_ff @(posedge clk) begin
		if (cmd.write) begin
			hist_mem[head_q] <= iv_q;
		end
		if (cmd.mem_read) begin
			rd_q <= hist_mem[head_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tps_q     <= TPS_RESET;
			min_q     <= '0;
			prev_q    <= '0;
			pause_q   <= '0;
			stopped_q <= 1'b1;
			head_q    <= '0;
			count_q   <= '0;
			sum_q     <= '0;
			mean_q    <= '0;
			wframes_q <= '0;
			wticks_q  <= '0;
			rate_q    <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_TICKS_PER_SECOND: tps_q <= cfg_data;
					CFG_MIN_FRAME_TICKS:  min_q <= cfg_data;
					default: ;
				endcase
			end

			if (cmd.check) begin
				unique case (mode_q)
					MODE_RESUME: begin
						if (stopped_q) begin
							prev_q    <= prev_q + aux_q;
							stopped_q <= 1'b0;
						end
					end
					MODE_PAUSE: begin
						if (!stopped_q) begin
							pause_q   <= ts_q;
							stopped_q <= 1'b1;
						end
					end
					MODE_RESET: begin
						prev_q    <= ts_q;
						stopped_q <= 1'b0;
					end
					default: ;
				endcase
			end

			if (cmd.apply && acc_q) begin
				prev_q <= ts_q;
				if (window_close) begin
					rate_q    <= frames_inc;
					wframes_q <= '0;
					wticks_q  <= '0;
				end else begin
					wframes_q <= frames_inc;
					wticks_q  <= wsum_q;
				end
			end

			if (cmd.evict) begin
				sum_q <= sum_q - SUM_W'(rd_q);
			end

			if (cmd.write) begin
				sum_q  <= sum_q + SUM_W'(iv_q);
				head_q <= head_nxt;
				if (!full) begin
					count_q <= count_q + 1'b1;
				end
			end

			if (cmd.mean_load) begin
				mean_q <= quotient;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			o_acc_q    <= acc_q;
			o_ticks_q  <= acc_q ? iv_q : '0;
			o_mean_q   <= mean_q;
			o_rate_q   <= rate_q;
			o_count_q  <= count_q;
			o_paused_q <= stopped_q;
		end
	end

	assign frame_accepted = o_acc_q;
	assign frame_ticks    = o_ticks_q;
	assign average_ticks  = o_mean_q;
	assign frame_rate     = o_rate_q;
	assign samples_held   = o_count_q;
	assign paused         = o_paused_q;

endmodule

// ===== test/frame_interval_monitor_core_test.sv =====
// ----------------------------------------------------------------------------
// frame_interval_monitor_core_test
// Self-checking bench for the frame interval monitor: a short directed table
// of requests and register writes, then random phases of frame marks with
// jitter, outliers, pauses, resumes and resets. Every response is compared
// against pinned values or a cycle-free model of the frame statistics here.
// ----------------------------------------------------------------------------
module frame_interval_monitor_core_test;

	timeunit 1ns;
	timeprecision 1ps;

	import fim_pkg::*;

	localparam int TW     = DEF_TIME_WIDTH;
	localparam int DEPTH  = DEF_HISTORY_DEPTH;
	localparam int HELD_W = $clog2(DEPTH + 1);
	localparam int SUM_W  = TW + $clog2(DEPTH);

	localparam int NUM_DIRECTED    = 26;
	localparam int NUM_PHASES      = 8;
	localparam int ITEMS_PER_PHASE = 125;
	// slowest request: an evicting frame mark, plus the output register
	localparam int DRAIN_CYCLES    = 40;

	// one response, field by field
	typedef struct packed {
		logic              accepted;
		logic [TW-1:0]     ticks;
		logic [TW-1:0]     mean;
		logic [RATE_W-1:0] rate;
		logic [HELD_W-1:0] held;
		logic              paused;
	} frame_stats_t;

	// one line of the directed plan: a register write or a request
	typedef struct {
		bit                     is_cfg;
		logic [CFG_INDEX_W-1:0] idx;
		logic [CFG_DATA_W-1:0]  data;
		mode_t                  m;
		logic [TW-1:0]          ts;
		bit                     pinned;
		frame_stats_t           typed;
	} plan_row_t;

	logic                     clk;
	logic                     arst_n    = 1'b0;
	logic                     cfg_valid = 1'b0;
	logic                     cfg_ready;
	logic [CFG_INDEX_W-1:0]   cfg_index = '0;
	logic [CFG_DATA_W-1:0]    cfg_data  = '0;
	logic                     in_valid  = 1'b0;
	logic                     in_ready;
	logic [MODE_W-1:0]        mode      = '0;
	logic [TW-1:0]            timestamp = '0;
	logic                     out_valid;
	logic                     out_ready = 1'b0;
	logic                     frame_accepted;
	logic [TW-1:0]            frame_ticks;
	logic [TW-1:0]            average_ticks;
	logic [RATE_W-1:0]        frame_rate;
	logic [HELD_W-1:0]        samples_held;
	logic                     paused;

	frame_interval_monitor_core #(
		.HISTORY_DEPTH(DEPTH),
		.TIME_WIDTH   (TW)
	) dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.mode          (mode),
		.timestamp     (timestamp),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.frame_accepted(frame_accepted),
		.frame_ticks   (frame_ticks),
		.average_ticks (average_ticks),
		.frame_rate    (frame_rate),
		.samples_held  (samples_held),
		.paused        (paused)
	);

	// ------------------------------------------------------------------------
	// Statistics model: registers and state as they stand after the last
	// accepted request or register write.
	// ------------------------------------------------------------------------
	logic [CFG_DATA_W-1:0] tps       = TPS_RESET;
	logic [CFG_DATA_W-1:0] min_ticks = '0;

	logic [TW-1:0]     hist [DEPTH];
	int unsigned       head       = 0;
	logic [HELD_W-1:0] count      = '0;
	logic [SUM_W-1:0]  sum        = '0;
	logic [TW-1:0]     mean       = '0;
	logic [TW-1:0]     prev_mark  = '0;
	logic [TW-1:0]     pause_at   = '0;
	logic              stopped    = 1'b1;
	logic [RATE_W-1:0] win_frames = '0;
	logic [TW-1:0]     win_ticks  = '0;
	logic [RATE_W-1:0] rate       = '0;

	frame_stats_t pending_stats [$];   // responses still owed, oldest first
	frame_stats_t oldest_stats;
	plan_row_t    directed_plan [NUM_DIRECTED];
	bit           failed = 1'b0;
	bit           calm   = 1'b0;       // no idling on either side

	// Apply one request to the model and return the response it should give.
	function automatic frame_stats_t advance_frame_stats(mode_t m, logic [TW-1:0] ts);
		logic [TW-1:0] iv;
		logic [TW-1:0] gap;
		frame_stats_t  r;
		r = '0;
		case (m)
			MODE_FRAME: begin
				iv = ts - prev_mark;
				// frame lock: too short a mark leaves everything alone
				if (!(min_ticks != 0 && iv < min_ticks)) begin
					prev_mark = ts;
					gap = (iv >= mean) ? iv - mean : mean - iv;
					// only samples within one second of the mean enter the ring
					if (gap < tps) begin
						if (count == DEPTH)
							sum = sum - hist[head];
						else
							count++;
						hist[head] = iv;
						sum = sum + iv;
						head = (head + 1) % DEPTH;
					end
					if (win_frames != RATE_MAX)
						win_frames++;
					if ({TW{1'b1}} - win_ticks < iv)
						win_ticks = '1;
					else
						win_ticks = win_ticks + iv;
					if (win_ticks > tps) begin
						rate = win_frames;
						win_frames = '0;
						win_ticks = '0;
					end
					mean = (count != 0) ? TW'(sum / count) : '0;
					r.accepted = 1'b1;
					r.ticks = iv;
				end
			end
			MODE_RESUME: begin
				if (stopped) begin
					prev_mark = prev_mark + (ts - pause_at);
					stopped = 1'b0;
				end
			end
			MODE_PAUSE: begin
				if (!stopped) begin
					pause_at = ts;
					stopped = 1'b1;
				end
			end
			default: begin
				prev_mark = ts;
				stopped = 1'b0;
			end
		endcase
		r.mean = mean;
		r.rate = rate;
		r.held = count;
		r.paused = stopped;
		return r;
	endfunction

	// ------------------------------------------------------------------------
	// Directed plan rows
	// ------------------------------------------------------------------------
	function automatic plan_row_t request_row(mode_t m, logic [TW-1:0] ts);
		plan_row_t r;
		r.is_cfg = 1'b0;
		r.idx = '0;
		r.data = '0;
		r.m = m;
		r.ts = ts;
		r.pinned = 1'b0;
		r.typed = '0;
		return r;
	endfunction

	function automatic plan_row_t pinned_row(mode_t m, logic [TW-1:0] ts, frame_stats_t s);
		plan_row_t r;
		r = request_row(m, ts);
		r.pinned = 1'b1;
		r.typed = s;
		return r;
	endfunction

	function automatic plan_row_t write_row(logic [CFG_INDEX_W-1:0] idx,
			logic [CFG_DATA_W-1:0] data);
		plan_row_t r;
		r = request_row(MODE_FRAME, '0);
		r.is_cfg = 1'b1;
		r.idx = idx;
		r.data = data;
		return r;
	endfunction

	function automatic frame_stats_t typed_stats(logic acc, logic [TW-1:0] ticks,
			logic [TW-1:0] avg, logic [RATE_W-1:0] fps, logic [HELD_W-1:0] held,
			logic stop);
		frame_stats_t s;
		s.accepted = acc;
		s.ticks = ticks;
		s.mean = avg;
		s.rate = fps;
		s.held = held;
		s.paused = stop;
		return s;
	endfunction

	// ------------------------------------------------------------------------
	// Clock and watchdog
	// ------------------------------------------------------------------------
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// ~1000 requests fit in this window many times over
	initial begin
		#5ms;
		$display("tb: failure");
		$finish;
	end

	// ------------------------------------------------------------------------
	// Request side. valid stays up with a stable payload until taken; it is
	// only dropped when a gap is inserted or the bench drains.
	// ------------------------------------------------------------------------
	task automatic send_request(mode_t m, logic [TW-1:0] ts, bit pinned,
			frame_stats_t typed);
		frame_stats_t s;
		if (!calm && $urandom_range(99) < 10) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 30)) @(posedge clk);
		end
		in_valid <= 1'b1;
		mode <= m;
		timestamp <= ts;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		// taken at this edge: the model moves on now
		s = advance_frame_stats(m, ts);
		pending_stats.push_back(pinned ? typed : s);
	endtask

	// Registers may only change with no request in flight.
	task automatic drain_requests();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_stats.size() != 0) @(posedge clk);
	endtask

	task automatic write_register(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		case (idx)
			CFG_TICKS_PER_SECOND: tps = data;
			CFG_MIN_FRAME_TICKS:  min_ticks = data;
			default: ;
		endcase
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// ------------------------------------------------------------------------
	// Response side: random back-pressure, then check against the oldest
	// expectation.
	// ------------------------------------------------------------------------
	always @(posedge clk)
		out_ready <= calm || ($urandom_range(99) >= 10);

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (pending_stats.size() == 0) begin
				$error("response with no request outstanding");
				failed = 1'b1;
			end else begin
				oldest_stats = pending_stats.pop_front();
				if (frame_accepted !== oldest_stats.accepted) begin
					$error("frame_accepted: expected %0d, got %0d",
						oldest_stats.accepted, frame_accepted);
					failed = 1'b1;
				end
				if (frame_ticks !== oldest_stats.ticks) begin
					$error("frame_ticks: expected %0d, got %0d",
						oldest_stats.ticks, frame_ticks);
					failed = 1'b1;
				end
				if (average_ticks !== oldest_stats.mean) begin
					$error("average_ticks: expected %0d, got %0d",
						oldest_stats.mean, average_ticks);
					failed = 1'b1;
				end
				if (frame_rate !== oldest_stats.rate) begin
					$error("frame_rate: expected %0d, got %0d",
						oldest_stats.rate, frame_rate);
					failed = 1'b1;
				end
				if (samples_held !== oldest_stats.held) begin
					$error("samples_held: expected %0d, got %0d",
						oldest_stats.held, samples_held);
					failed = 1'b1;
				end
				if (paused !== oldest_stats.paused) begin
					$error("paused: expected %0d, got %0d",
						oldest_stats.paused, paused);
					failed = 1'b1;
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------------
	initial begin
		logic [TW-1:0]         now;
		logic [TW-1:0]         ts;
		logic [CFG_DATA_W-1:0] new_tps;
		logic [CFG_DATA_W-1:0] new_min;
		int unsigned           period;
		int unsigned           jitter;
		int unsigned           pick;
		mode_t                 m;

		directed_plan = '{
			// timer comes out of reset stopped: pause is a no-op
			pinned_row(MODE_PAUSE, 48'd100, typed_stats(1'b0, '0, '0, '0, '0, 1'b1)),
			// resume from a zero pause mark: last mark moves to 1100
			pinned_row(MODE_RESUME, 48'd1100, typed_stats(1'b0, '0, '0, '0, '0, 1'b0)),
			// zero interval is stored, mean stays zero
			pinned_row(MODE_FRAME, 48'd1100, typed_stats(1'b1, '0, '0, '0, 7'd1, 1'b0)),
			request_row(MODE_FRAME, 48'd2100),
			request_row(MODE_FRAME, 48'd5100),
			request_row(MODE_RESUME, 48'd6000),          // ignored while running
			request_row(MODE_PAUSE, 48'd7000),
			request_row(MODE_PAUSE, 48'd8000),           // ignored while stopped
			request_row(MODE_FRAME, 48'd9000),           // marks still count when paused
			request_row(MODE_RESUME, 48'd20000),
			request_row(MODE_FRAME, 48'h8000_0000_0000), // outlier, closes the window
			request_row(MODE_RESET, 48'hFFFF_FFFF_FFFF),
			request_row(MODE_FRAME, 48'd5),              // interval wraps past zero
			write_row(CFG_MIN_FRAME_TICKS, 32'hFFFF_FFFF),
			request_row(MODE_FRAME, 48'd100),            // below the lock, rejected
			request_row(MODE_FRAME, 48'h1_0000_0005),    // just above the lock
			write_row(CFG_TICKS_PER_SECOND, 32'd0),
			write_row(CFG_MIN_FRAME_TICKS, 32'd0),
			request_row(MODE_FRAME, 48'h1_0000_0105),    // zero second: any tick closes
			request_row(MODE_FRAME, 48'h1_0000_0105),    // zero interval does not
			write_row(CFG_TICKS_PER_SECOND, 32'hFFFF_FFFF),
			request_row(MODE_RESET, 48'd0),
			request_row(MODE_FRAME, 48'd10),
			request_row(MODE_FRAME, 48'd9),              // full-scale interval saturates
			request_row(MODE_PAUSE, 48'hFFFF_FFFF_FFFF),
			request_row(MODE_RESUME, 48'd0)              // pause length wraps
		};

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_plan[i]) begin
			if (directed_plan[i].is_cfg) begin
				drain_requests();
				write_register(directed_plan[i].idx, directed_plan[i].data);
			end else begin
				send_request(directed_plan[i].m, directed_plan[i].ts,
					directed_plan[i].pinned, directed_plan[i].typed);
			end
		end

		// Random phases. The frame period stays near one value so the mean
		// keeps tracking it and the history fills and wraps; the second length
		// and the lock vary per phase so the window closes after varying numbers of frames.
		now = {16'($urandom), $urandom};
		for (int phase = 0; phase < NUM_PHASES; phase++) begin
			period = $urandom_range(800, 1200);
			jitter = period / 8;
			case (phase % 4)
				0: begin
					new_tps = period * $urandom_range(4, 64);
					new_min = '0;
				end
				1: begin
					new_tps = period * $urandom_range(4, 64);
					new_min = period - $urandom_range(0, period / 4);
				end
				2: begin
					new_tps = 32'hFFFF_FFFF;
					new_min = $urandom_range(0, 3);
				end
				default: begin
					// a one- or few-tick second: almost nothing is stored
					new_tps = $urandom_range(1, 3);
					new_min = '0;
					jitter = 0;
				end
			endcase
			if (phase == 7) new_tps = $urandom;
			// run one phase across the top of the timestamp range
			if (phase == 5) now = {TW{1'b1}} - $urandom_range(0, 20000);

			drain_requests();
			write_register(CFG_TICKS_PER_SECOND, new_tps);
			write_register(CFG_MIN_FRAME_TICKS, new_min);
			calm = (phase == 2);

			repeat (ITEMS_PER_PHASE) begin
				pick = $urandom_range(99);
				if (pick < 70) begin
					m = MODE_FRAME;
					ts = now + period - jitter + $urandom_range(0, 2 * jitter);
				end else if (pick < 75) begin
					m = MODE_FRAME;                    // early mark, under a lock set near the period
					ts = now + $urandom_range(0, period / 2);
				end else if (pick < 79) begin
					m = MODE_FRAME;                    // long stall, outlier
					ts = now + {16'($urandom_range(0, 255)), $urandom};
				end else if (pick < 85) begin
					m = MODE_PAUSE;
					ts = now + $urandom_range(0, period);
				end else if (pick < 91) begin
					m = MODE_RESUME;
					ts = now + $urandom_range(0, 4 * period);
				end else if (pick < 95) begin
					m = MODE_RESET;
					ts = now + $urandom_range(0, period);
				end else begin
					m = mode_t'($urandom_range(3));   // noise
					ts = {16'($urandom), $urandom};
				end
				now = ts;
				send_request(m, ts, 1'b0, '0);
			end
		end
		calm = 1'b0;

		in_valid <= 1'b0;
		while (pending_stats.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (!failed)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/fim_pkg.sv
rtl/fim_ctrl.sv
rtl/fim_divider.sv
rtl/fim_datapath.sv
rtl/frame_interval_monitor_core.sv
test/frame_interval_monitor_core_test.sv
